@@ design/emv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emv_pkg: shared definitions for the encoder multi-turn velocity block
// Field widths, word formats and scaling constants used by the divider and the top level.
// ----------------------------------------------------------------------------
package emv_pkg;

    // default geometry
    localparam int ANGLE_BITS = 14;
    localparam int TURN_BITS  = 16;

    // fixed field widths
    localparam int SENSOR_W = 14;
    localparam int TIMER_W  = 24;
    localparam int POS_W    = 30;
    localparam int VEL_W    = 32;
    localparam int CLK_W    = 8;
    localparam int HZ_W     = 28;   // holds 255 MHz in Hz
    localparam int VMAG_W   = 31;   // velocity magnitude

    localparam logic [HZ_W-1:0]    HZ_PER_MHZ = 28'd1000000;
    localparam logic [HZ_W-1:0]    HZ_RESET   = 28'd72000000;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 24'hFFFFFF;
    localparam logic [VMAG_W-1:0]  VEL_MAX    = 31'h7FFFFFFF;
    localparam logic [9:0]         MS_SCALE   = 10'd1000;   // 1 ms fallback

    // input word
    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_angle;
        logic [TIMER_W-1:0]  timer_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
    } t_out_word;

    // configuration word
    typedef struct packed {
        logic [CLK_W-1:0] clock_mhz;
    } t_cfg_word;

endpackage

@@ design/emv_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emv_chan_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface emv_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/emv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emv_div: bit-serial restoring divider
// One quotient bit per cycle; the numerator shifts out MSB first while the
// quotient shifts in behind it. Pulses o_done when the quotient is ready.
// ----------------------------------------------------------------------------
module emv_div #(
    parameter int NUM_W = emv_pkg::ANGLE_BITS + emv_pkg::HZ_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [emv_pkg::TIMER_W-1:0] i_den,
    output logic                        o_done,
    output logic [NUM_W-1:0]            o_quot
);
    localparam int DEN_W = emv_pkg::TIMER_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DEN_W-1:0] r_den,  n_den;
    logic [DEN_W-1:0] r_rem,  n_rem;
    logic [NUM_W-1:0] r_num,  n_num;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             q_bit;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_num[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        q_bit   = (shifted >= {1'b0, r_den});
    end

    // step control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_num  = r_num;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_den  = i_den;
            n_rem  = '0;
            n_num  = i_num;
        end else if (r_busy) begin
            n_rem = q_bit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_num = {r_num[NUM_W-2:0], q_bit};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_num <= n_num;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ design/encoder_multiturn_velocity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity: multi-turn unwrap and speed of an encoder
// Tracks turns of a single-turn absolute angle and estimates speed in
// counts per second from a 24-bit down-counting tick timer.
// ----------------------------------------------------------------------------
// Usage: one word in, one word out. The block takes one word at a time.
// A word whose interval is zero or longer than half a second (1 ms is used
// instead) skips the divider and goes from S_PREP and S_MUL straight to
// S_OUT. Any other word also passes through S_DIV, where the bit-serial
// divider forms counts * Hz / ticks one quotient bit per cycle over
// ANGLE_BITS + 28 steps. The result sits in an output register,
// so the next word may be accepted before the previous one is taken.
// clock_mhz is written through i_cfg, which is always ready; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity #(
    parameter int ANGLE_BITS = emv_pkg::ANGLE_BITS,
    parameter int TURN_BITS  = emv_pkg::TURN_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    emv_chan_if.sink    i_in,
    emv_chan_if.sink    i_cfg,
    emv_chan_if.source  o_out
);
    localparam int AB     = ANGLE_BITS;
    localparam int HZ_W   = emv_pkg::HZ_W;
    localparam int TIM_W  = emv_pkg::TIMER_W;
    localparam int VMAG_W = emv_pkg::VMAG_W;
    localparam int VEL_W  = emv_pkg::VEL_W;
    localparam int POS_W  = emv_pkg::POS_W;
    localparam int NUM_W  = AB + HZ_W;
    localparam logic [AB+2:0] CROSS_LIM = {3'b100, {AB{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // |d| * 5 > 4 * full turn
    function automatic logic f_cross(input logic [AB-1:0] m);
        logic [AB+2:0] m5;
        m5 = {m, 2'b00} + (AB+3)'(m);
        return m5 > CROSS_LIM;
    endfunction

    t_state r_state, n_state;

    logic [HZ_W-1:0]      r_hz;
    logic [AB-1:0]        r_last_angle;
    logic [TURN_BITS-1:0] r_turn, n_turn;
    logic [AB-1:0]        r_last_spd;
    logic [TIM_W-1:0]     r_last_timer;

    logic [AB-1:0]        r_angle;
    logic [TIM_W-1:0]     r_now;
    logic [POS_W-1:0]     r_pos;
    logic [TIM_W-1:0]     r_ticks;
    logic [AB-1:0]        r_mag;
    logic                 r_neg;
    logic [VMAG_W-1:0]    r_vmag;

    emv_pkg::t_out_word   r_out;
    logic                 r_out_valid;

    // unwrap and delta terms
    logic [AB:0]          d_turn, d_spd;
    logic [AB-1:0]        mag_turn, mag_spd;
    logic                 neg_turn, neg_spd;
    logic                 cross_turn, cross_spd;
    logic [TIM_W-1:0]     ticks;

    // velocity terms
    logic                 short_ivl;
    logic [VMAG_W-1:0]    v_short;
    logic [NUM_W-1:0]     prod;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;
    logic [VMAG_W-1:0]    v_sat;
    logic                 out_load;
    logic [VEL_W-1:0]     vel_word;

    // angle deltas, crossing tests and elapsed ticks
    always_comb begin
        d_turn     = {1'b0, r_angle} - {1'b0, r_last_angle};
        neg_turn   = d_turn[AB];
        mag_turn   = neg_turn ? AB'(-d_turn) : d_turn[AB-1:0];
        cross_turn = f_cross(mag_turn);

        d_spd      = {1'b0, r_angle} - {1'b0, r_last_spd};
        neg_spd    = d_spd[AB];
        mag_spd    = neg_spd ? AB'(-d_spd) : d_spd[AB-1:0];
        cross_spd  = f_cross(mag_spd);

        n_turn = r_turn;
        if (cross_turn) begin
            n_turn = neg_turn ? r_turn + TURN_BITS'(1) : r_turn - TURN_BITS'(1);
        end

        if (r_now < r_last_timer) begin
            ticks = r_last_timer - r_now;
        end else begin
            ticks = emv_pkg::TIMER_MAX - r_now + r_last_timer;
        end
    end

    // interval fallback, divider operand, saturation, strobes and signed velocity
    always_comb begin
        short_ivl = (r_ticks == '0) || (HZ_W'({r_ticks, 1'b0}) > r_hz);
        v_short   = VMAG_W'(r_mag) * VMAG_W'(emv_pkg::MS_SCALE);
        prod      = NUM_W'(r_mag) * NUM_W'(r_hz);
        v_sat     = (div_quot > NUM_W'(emv_pkg::VEL_MAX)) ? emv_pkg::VEL_MAX
                                                         : VMAG_W'(div_quot);
        div_start = (r_state == S_MUL) && !short_ivl;
        out_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
        vel_word  = r_neg ? VEL_W'(-{1'b0, r_vmag}) : VEL_W'({1'b0, r_vmag});
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_PREP;
            end
            S_PREP: n_state = S_MUL;
            S_MUL: begin
                n_state = short_ivl ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hz         <= emv_pkg::HZ_RESET;
            r_last_angle <= '0;
            r_turn       <= '0;
            r_last_spd   <= '0;
            r_last_timer <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_hz <= HZ_W'(i_cfg.data.clock_mhz) * emv_pkg::HZ_PER_MHZ;
            end
            if (r_state == S_PREP) begin
                r_last_angle <= r_angle;
                r_turn       <= n_turn;
                r_last_spd   <= r_angle;
                r_last_timer <= r_now;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_angle <= AB'(i_in.data.sensor_angle);
            r_now   <= i_in.data.timer_value;
        end
        if (r_state == S_PREP) begin
            r_pos   <= POS_W'($signed({n_turn, r_angle}));
            r_ticks <= ticks;
            r_mag   <= cross_spd ? AB'(-mag_spd) : mag_spd;
            r_neg   <= cross_spd ? !neg_spd : neg_spd;
        end
        if (r_state == S_MUL) begin
            r_vmag <= v_short;
        end
        if (r_state == S_DIV && div_done) begin
            r_vmag <= v_sat;
        end
        if (out_load) begin
            r_out.position <= $signed(r_pos);
            r_out.velocity <= $signed(vel_word);
        end
    end

    emv_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (r_ticks),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
